// File: src/fal_pkg.sv
`timescale 1ns / 1ps
package fal_pkg;

    localparam int FRAMES  = 64;
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int COUNT_W = $clog2(FRAMES + 1);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FRAME  = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    typedef enum logic [1:0] {
        WR_ALLOC,
        WR_FREE,
        WR_TOUCH
    } wr_kind_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic               free_hit;
        logic [FRAME_W-1:0] free_idx;
        logic               cl_hit;
        logic [FRAME_W-1:0] cl_idx;
        logic [31:0]        cl_stamp;
        logic [15:0]        cl_owner;
        logic [15:0]        cl_page;
        logic               an_hit;
        logic [FRAME_W-1:0] an_idx;
        logic [31:0]        an_stamp;
        logic [15:0]        an_owner;
        logic [15:0]        an_page;
        logic               an_dirty;
        logic               tgt_alloc;
    } scan_t;

    // update broadcast to every cell
    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] idx;
        wr_kind_t           kind;
        logic [15:0]        owner;
        logic [15:0]        page;
        logic [31:0]        stamp;
        logic               set_dirty;
    } wcmd_t;

endpackage

// File: src/fal_cell.sv
`timescale 1ns / 1ps
module fal_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [fal_pkg::FRAME_W-1:0] idx,
    input  logic [fal_pkg::FRAME_W-1:0] tgt,
    input  fal_pkg::wcmd_t         wcmd,
    input  fal_pkg::scan_t         tok_in,
    output fal_pkg::scan_t         tok_out
);
    import fal_pkg::*;

    logic        alloc_reg;
    logic        dirty_reg;
    logic [15:0] owner_reg;
    logic [15:0] page_reg;
    logic [31:0] stamp_reg;
    scan_t       tok_reg;
    scan_t       tok_next;
    logic        sel;

    assign sel     = wcmd.we && (wcmd.idx == idx);
    assign tok_out = tok_reg;

    always_comb
    begin
        tok_next = tok_in;
        if (!alloc_reg && !tok_in.free_hit)
        begin
            tok_next.free_hit = 1'b1;
            tok_next.free_idx = idx;
        end
        // pinned owner never a victim
        if (alloc_reg && owner_reg != 16'd0)
        begin
            if (!dirty_reg && (!tok_in.cl_hit || stamp_reg < tok_in.cl_stamp))
            begin
                tok_next.cl_hit   = 1'b1;
                tok_next.cl_idx   = idx;
                tok_next.cl_stamp = stamp_reg;
                tok_next.cl_owner = owner_reg;
                tok_next.cl_page  = page_reg;
            end
            if (!tok_in.an_hit || stamp_reg < tok_in.an_stamp)
            begin
                tok_next.an_hit   = 1'b1;
                tok_next.an_idx   = idx;
                tok_next.an_stamp = stamp_reg;
                tok_next.an_owner = owner_reg;
                tok_next.an_page  = page_reg;
                tok_next.an_dirty = dirty_reg;
            end
        end
        if (tgt == idx)
        begin
            tok_next.tgt_alloc = alloc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg <= 1'b0;
            dirty_reg <= 1'b0;
            owner_reg <= 16'd0;
            page_reg  <= 16'd0;
        end
        else if (sel)
        begin
            case (wcmd.kind)
                WR_ALLOC:
                begin
                    alloc_reg <= 1'b1;
                    dirty_reg <= 1'b0;
                    owner_reg <= wcmd.owner;
                    page_reg  <= wcmd.page;
                end
                WR_FREE:
                begin
                    alloc_reg <= 1'b0;
                    dirty_reg <= 1'b0;
                    owner_reg <= 16'd0;
                    page_reg  <= 16'd0;
                end
                WR_TOUCH:
                begin
                    dirty_reg <= dirty_reg | wcmd.set_dirty;
                end
                default:
                begin
                    alloc_reg <= alloc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && (wcmd.kind == WR_ALLOC || wcmd.kind == WR_TOUCH))
        begin
            stamp_reg <= wcmd.stamp;
        end
        tok_reg <= tok_next;
    end

endmodule

// File: src/frame_allocator_lru_victim_unit.sv
`timescale 1ns / 1ps
// channel | signals                                              | direction
// input   | in_valid/in_ready, operation owner_id virtual_page   | in
//         | frame now                                            |
// output  | out_valid/out_ready, frame_out status evicted        | out
//         | evicted_process evicted_page evicted_dirty           |
//         | frames_free                                          |
// each item: the search token walks the chain of 64 cells, one frame cell
// per cycle, the table is updated in the final state, and the unit then
// returns to idle before the next item is taken
// one item at a time; a new item is taken while the last result still waits
// the table update and the new result hold in the final state until the
// previous result has been taken
// rst_n clears all frames to free and the free count to 64, no sweep needed
module frame_allocator_lru_victim_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] owner_id,
    input  logic [15:0] virtual_page,
    input  logic [6:0]  frame,
    input  logic [31:0] now,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  frame_out,
    output logic [1:0]  status,
    output logic        evicted,
    output logic [15:0] evicted_process,
    output logic [15:0] evicted_page,
    output logic        evicted_dirty,
    output logic [6:0]  frames_free
);
    import fal_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [FRAME_W-1:0]  cnt_reg;
    logic [COUNT_W-1:0]  free_reg, free_next;
    logic                out_valid_reg;

    // captured item
    logic [1:0]          op_reg;
    logic [15:0]         pid_reg;
    logic [15:0]         vpage_reg;
    logic [6:0]          fr_reg;
    logic [31:0]         now_reg;

    // result registers
    logic [5:0]          fo_reg, fo_next;
    logic [1:0]          st_reg, st_next;
    logic                ev_reg, ev_next;
    logic [15:0]         evp_reg, evp_next;
    logic [15:0]         evg_reg, evg_next;
    logic                evd_reg, evd_next;

    scan_t               tok [FRAMES+1];
    wcmd_t               wcmd;
    scan_t               res;
    logic                accept;
    logic                finish;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign finish    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign frame_out = fo_reg;
    assign status    = st_reg;
    assign evicted   = ev_reg;
    assign evicted_process = evp_reg;
    assign evicted_page    = evg_reg;
    assign evicted_dirty   = evd_reg;
    assign frames_free     = free_reg;
    assign res       = tok[FRAMES];
    assign tok[0]    = '0;

    // chain of frame cells, one frame each
    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        fal_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (FRAME_W'(i)),
            .tgt     (fr_reg[FRAME_W-1:0]),
            .wcmd    (wcmd),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    // decide result and table update from the token at the chain end
    always_comb
    begin
        wcmd           = '0;
        wcmd.kind      = WR_TOUCH;
        wcmd.owner     = pid_reg;
        wcmd.page      = vpage_reg;
        wcmd.stamp     = now_reg;
        wcmd.set_dirty = (op_reg == OP_WRITE);
        wcmd.idx       = fr_reg[FRAME_W-1:0];
        free_next      = free_reg;
        fo_next        = fr_reg[5:0];
        st_next        = ST_OK;
        ev_next        = 1'b0;
        evp_next       = 16'd0;
        evg_next       = 16'd0;
        evd_next       = 1'b0;
        if (op_reg == OP_ALLOC)
        begin
            wcmd.kind = WR_ALLOC;
            if (res.free_hit)
            begin
                wcmd.we   = 1'b1;
                wcmd.idx  = res.free_idx;
                fo_next   = res.free_idx;
                free_next = free_reg - COUNT_W'(1);
            end
            else if (res.cl_hit)
            begin
                // clean victim preferred
                wcmd.we  = 1'b1;
                wcmd.idx = res.cl_idx;
                fo_next  = res.cl_idx;
                ev_next  = 1'b1;
                evp_next = res.cl_owner;
                evg_next = res.cl_page;
            end
            else if (res.an_hit)
            begin
                wcmd.we  = 1'b1;
                wcmd.idx = res.an_idx;
                fo_next  = res.an_idx;
                ev_next  = 1'b1;
                evp_next = res.an_owner;
                evg_next = res.an_page;
                evd_next = res.an_dirty;
            end
            else
            begin
                st_next = ST_NO_FRAME;
                fo_next = 6'd0;
            end
        end
        else if (fr_reg[6])
        begin
            st_next = ST_RANGE;
        end
        else if (!res.tgt_alloc)
        begin
            st_next = ST_NOT_ALLOC;
        end
        else if (op_reg == OP_FREE)
        begin
            wcmd.we   = 1'b1;
            wcmd.kind = WR_FREE;
            free_next = free_reg + COUNT_W'(1);
        end
        else
        begin
            wcmd.we = 1'b1;
        end
        if (!finish)
        begin
            wcmd.we = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == FRAME_W'(FRAMES - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            free_reg      <= COUNT_W'(FRAMES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                cnt_reg <= cnt_reg + FRAME_W'(1);
            end
            if (finish)
            begin
                free_reg      <= free_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            pid_reg   <= owner_id;
            vpage_reg <= virtual_page;
            fr_reg    <= frame;
            now_reg   <= now;
        end
        if (finish)
        begin
            fo_reg  <= fo_next;
            st_reg  <= st_next;
            ev_reg  <= ev_next;
            evp_reg <= evp_next;
            evg_reg <= evg_next;
            evd_reg <= evd_next;
        end
    end

endmodule
